// ===== rtl/core/nwfs_pkg.sv =====
// Shared constants and types of the no-wait flow shop makespan block.
package nwfs_pkg;

	localparam int MAX_STAGES = 64;
	localparam int IDX_W      = $clog2(MAX_STAGES);
	localparam int CNT_W      = 7;
	localparam int SKILL_W    = 16;
	localparam int MANA_W     = 16;
	localparam int PROD_W     = SKILL_W + MANA_W;
	localparam int TIME_W     = 48;
	localparam int APB_DW     = 32;
	localparam int APB_AW     = 3;

	// Register indexes on the configuration port.
	localparam logic REG_STAGE_COUNT = 1'b0;

	// Item kinds carried on the input tuser.
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_JOB  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FWD,
		ST_BWD,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/core/no_wait_flow_shop_makespan.sv =====
// Top level of the no-wait flow shop makespan block: sequencer, memories and datapath.
// A load item yields no result. A job item with n active stages is worked through n
// forward reads and n - 1 backward reads, issued in turn through the single read port of
// the finish time memory, and a three deep read, multiply, add pipeline; no new item is
// taken until the job's result has been loaded into the output register.
// arst_n clears the control state, stage_count to 1, the overflow flag and the
// per-entry valid bits of the finish times, so every finish time reads as zero.
module no_wait_flow_shop_makespan
	import nwfs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// Input stream.
	input  logic              s_tvalid,
	output logic              s_tready,
	// tdata: stage_index[5:0], skill_value[21:6], mana_value[37:22], first_job[38], zero[39].
	input  logic [39:0]       s_tdata,
	// tuser: mode.
	input  logic              s_tuser,
	// Result stream.
	output logic              m_tvalid,
	input  logic              m_tready,
	// tdata: makespan[47:0].
	output logic [47:0]       m_tdata,
	// tuser: overflow.
	output logic              m_tuser,
	// Configuration port.
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	// Input payload fields.
	logic [IDX_W-1:0]   in_stage_index;
	logic [SKILL_W-1:0] in_skill_value;
	logic [MANA_W-1:0]  in_mana_value;
	logic               in_first_job;

	assign in_stage_index = s_tdata[5:0];
	assign in_skill_value = s_tdata[21:6];
	assign in_mana_value  = s_tdata[37:22];
	assign in_first_job   = s_tdata[38];

	// Configuration register. Only stage_count exists; pready never stalls.
	logic [CNT_W-1:0] stage_count_q;
	logic             cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_STAGE_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_count_q <= CNT_W'(1);
		end else if (cfg_write) begin
			stage_count_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_STAGE_COUNT) begin
			prdata = {{(APB_DW-CNT_W){1'b0}}, stage_count_q};
		end
	end

	// Index of the last active stage, with stage_count clamped to 1..MAX_STAGES.
	logic [IDX_W-1:0] last_stage;

	always_comb begin
		if (stage_count_q == '0) begin
			last_stage = '0;
		end else if (stage_count_q > CNT_W'(MAX_STAGES)) begin
			last_stage = IDX_W'(MAX_STAGES - 1);
		end else begin
			last_stage = IDX_W'(stage_count_q - CNT_W'(1));
		end
	end

	// Sequencer.
	state_t state_q, state_d;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] last_q;
	logic [MANA_W-1:0] mana_q;
	logic v_s1, v_s2;

	logic in_xfer, job_xfer, load_xfer;
	logic issue, issue_fwd, result_load;

	assign in_xfer   = s_tvalid && s_tready;
	assign job_xfer  = in_xfer && (s_tuser == MODE_JOB);
	assign load_xfer = in_xfer && (s_tuser == MODE_LOAD);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (job_xfer) state_d = ST_FWD;
			end
			ST_FWD: begin
				if (idx_q == last_q) state_d = (last_q == '0) ? ST_DRAIN : ST_BWD;
			end
			ST_BWD: begin
				if (idx_q == IDX_W'(1)) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!m_tvalid || m_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready    = 1'b0;
		issue       = 1'b0;
		issue_fwd   = 1'b0;
		result_load = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_FWD: begin
				issue     = 1'b1;
				issue_fwd = 1'b1;
			end
			ST_BWD:  issue = 1'b1;
			ST_DRAIN: ;
			ST_DONE: result_load = !m_tvalid || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			last_q  <= '0;
		end else begin
			state_q <= state_d;
			if (job_xfer) begin
				idx_q  <= '0;
				last_q <= last_stage;
			end else if (state_q == ST_FWD) begin
				// On the last forward read the index already points at the last stage,
				// where the backward walk begins.
				if (idx_q != last_q) idx_q <= idx_q + IDX_W'(1);
			end else if (state_q == ST_BWD) begin
				idx_q <= idx_q - IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_xfer) mana_q <= in_mana_value;
	end

	// Memories. The skill table is written by load items; the finish time memory
	// is written from the last pipeline stage. Both are read in the issue cycle.
	logic [SKILL_W-1:0] skill_mem [MAX_STAGES];
	logic [TIME_W-1:0]  fin_mem   [MAX_STAGES];
	logic [MAX_STAGES-1:0] fin_valid_q;

	logic [SKILL_W-1:0] skill_rd_s1;
	logic [TIME_W-1:0]  fin_rd_s1;
	logic               fin_vld_s1;
	logic               fwd_s1;
	logic [IDX_W-1:0]   idx_s1;

	logic               fin_we;
	logic [IDX_W-1:0]   fin_waddr;
	logic [TIME_W-1:0]  fin_wdata;

	always_ff @(posedge clk) begin
		if (load_xfer) skill_mem[in_stage_index] <= in_skill_value;
		if (issue) skill_rd_s1 <= skill_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (fin_we) fin_mem[fin_waddr] <= fin_wdata;
		if (issue) fin_rd_s1 <= fin_mem[idx_q];
	end

	// An entry whose valid bit is clear reads as zero; first_job clears them all.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_valid_q <= '0;
		end else if (job_xfer && in_first_job) begin
			fin_valid_q <= '0;
		end else if (fin_we) begin
			fin_valid_q[fin_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			fin_vld_s1 <= fin_valid_q[idx_q];
			fwd_s1     <= issue_fwd;
			idx_s1     <= idx_q;
		end
	end

	// Stage two: the stage's processing time, one 16 by 16 product.
	logic [PROD_W-1:0] prod_s2;
	logic [TIME_W-1:0] fin_s2;
	logic              fwd_s2;
	logic [IDX_W-1:0]  idx_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_s2 <= PROD_W'(skill_rd_s1) * PROD_W'(mana_q);
			fin_s2  <= fin_vld_s1 ? fin_rd_s1 : '0;
			fwd_s2  <= fwd_s1;
			idx_s2  <= idx_s1;
		end
	end

	// Last stage: the forward pass starts each stage at the later of the previous
	// stage's new finish and its own old finish; the backward pass shifts earlier
	// stages so that each ends exactly when the next one starts.
	logic [TIME_W-1:0] run_q;
	logic [TIME_W-1:0] makespan_q;
	logic              ovf_q;
	logic [TIME_W-1:0] fwd_start;
	logic [TIME_W:0]   fwd_sum;
	logic [TIME_W-1:0] bwd_diff;

	assign fwd_start = (run_q > fin_s2) ? run_q : fin_s2;
	assign fwd_sum   = {1'b0, fwd_start} + (TIME_W + 1)'(prod_s2);
	assign bwd_diff  = run_q - TIME_W'(prod_s2);

	assign fin_we    = v_s2;
	assign fin_waddr = fwd_s2 ? idx_s2 : (idx_s2 - IDX_W'(1));
	assign fin_wdata = fwd_s2 ? fwd_sum[TIME_W-1:0] : bwd_diff;

	always_ff @(posedge clk) begin
		if (job_xfer) begin
			// Stage zero starts at its own old finish time.
			run_q <= '0;
		end else if (v_s2) begin
			run_q <= fin_wdata;
			if (fwd_s2 && (idx_s2 == last_q)) makespan_q <= fwd_sum[TIME_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q <= 1'b0;
		end else if (job_xfer && in_first_job) begin
			ovf_q <= 1'b0;
		end else if (v_s2 && fwd_s2 && fwd_sum[TIME_W]) begin
			ovf_q <= 1'b1;
		end
	end

	// Output register: the next item is taken while a result waits here.
	logic m_tvalid_q;
	logic [TIME_W-1:0] m_data_q;
	logic m_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (result_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			m_data_q <= makespan_q;
			m_ovf_q  <= ovf_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_ovf_q;

	// The pipeline is empty whenever a new item can be taken or a result is loaded.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!v_s1 && !v_s2))
		else $error("pipeline busy while the sequencer is idle");

	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (!v_s1 && !v_s2))
		else $error("result loaded before the pipeline drained");

	// A backward step never targets a stage below zero.
	a_bwd_index: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !fwd_s2) |-> (idx_s2 != '0))
		else $error("backward step at stage zero");

	// Every read result held in stage one moves on to the write stage in the next cycle.
	a_pipe_flow: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |=> v_s2)
		else $error("pipeline lost a stage");

endmodule

// ===== dv/tb_no_wait_flow_shop_makespan.sv =====
// Self-checking testbench for the no-wait flow shop makespan block.
`timescale 1ns / 1ps

module tb_no_wait_flow_shop_makespan;
	import nwfs_pkg::*;

	// Percentage of cycles in which either side holds back, and the run's cycle budget.
	// The budget covers roughly 600 items, with stalls, many times over.
	localparam int IDLE_PCT    = 21;
	localparam int CYCLE_LIMIT = 2000000;

	// One input item as the stream carries it, and one result.
	typedef struct {
		logic               mode;
		logic [IDX_W-1:0]   stage;
		logic [SKILL_W-1:0] skill;
		logic [MANA_W-1:0]  mana;
		logic               first;
	} flow_item_t;

	typedef struct {
		logic [TIME_W-1:0] makespan;
		logic              overflow;
	} span_t;

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	// tdata: stage_index[5:0], skill_value[21:6], mana_value[37:22], first_job[38], zero[39].
	logic [39:0]       s_tdata = '0;
	// tuser: mode.
	logic              s_tuser = MODE_LOAD;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	// tdata: makespan[47:0].
	logic [47:0]       m_tdata;
	// tuser: overflow.
	logic              m_tuser;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [APB_AW-1:0] paddr   = '0;
	logic [APB_DW-1:0] pwdata  = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	no_wait_flow_shop_makespan u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Free-running clock, 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Items waiting to be sent, and the makespans the block owes us, oldest first.
	flow_item_t item_q[$];
	span_t      span_q[$];
	flow_item_t cur_item;
	flow_item_t popped_item;
	span_t      got_span;
	span_t      want_span;

	int  items_pushed = 0;
	int  items_taken  = 0;
	int  errors       = 0;
	int  cycles       = 0;
	bit  in_took      = 1'b0;
	bit  calm         = 1'b0;
	bit  pause_send   = 1'b0;

	// Shadow of the block's state. The predictor updates it at every accepted item.
	logic [SKILL_W-1:0] skill_tab [MAX_STAGES];
	logic [TIME_W-1:0]  fin_time  [MAX_STAGES];
	logic               ovf_seen  = 1'b0;
	logic [CNT_W-1:0]   stage_reg = CNT_W'(1);

	// Which skill entries the generated stream has written so far, and the stage count
	// that will be in force when the items queued now are processed.
	bit                 gen_known [MAX_STAGES];
	logic [CNT_W-1:0]   gen_count = CNT_W'(1);
	int                 phase_stages [8];

	// The block clamps the stage count register into 1..MAX_STAGES.
	function automatic int active_stages(input logic [CNT_W-1:0] cnt);
		if (cnt == 0)
			return 1;
		if (int'(cnt) > MAX_STAGES)
			return MAX_STAGES;
		return int'(cnt);
	endfunction

	function automatic logic [PROD_W-1:0] stage_prod(input int s, input logic [MANA_W-1:0] mana);
		return PROD_W'(skill_tab[s]) * PROD_W'(mana);
	endfunction

	// Applies one accepted item to the shadow state. A job runs the forward max-plus pass,
	// where any carry out of 48 bits sets the sticky overflow, then the backward pass that
	// pulls earlier stages up against the later ones so that the job never waits.
	function automatic void schedule_item(input flow_item_t it);
		int                n;
		logic [TIME_W-1:0] start;
		logic [TIME_W:0]   sum;
		span_t             res;
		if (it.mode == MODE_LOAD) begin
			skill_tab[it.stage] = it.skill;
		end else begin
			if (it.first) begin
				for (int i = 0; i < MAX_STAGES; i++)
					fin_time[i] = '0;
				ovf_seen = 1'b0;
			end
			n = active_stages(stage_reg);
			for (int i = 0; i < n; i++) begin
				start = fin_time[i];
				if (i > 0 && fin_time[i-1] > start)
					start = fin_time[i-1];
				sum = {1'b0, start} + (TIME_W+1)'(stage_prod(i, it.mana));
				if (sum[TIME_W])
					ovf_seen = 1'b1;
				fin_time[i] = sum[TIME_W-1:0];
			end
			for (int i = n - 1; i > 0; i--)
				fin_time[i-1] = fin_time[i] - TIME_W'(stage_prod(i, it.mana));
			res.makespan = fin_time[n-1];
			res.overflow = ovf_seen;
			span_q.push_back(res);
		end
	endfunction

	// Field values with the extremes drawn often.
	function automatic logic [15:0] pick16();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(16'hFFFF));
		endcase
	endfunction

	// A load carries random job fields, which the block must ignore.
	function automatic void push_load(input int idx, input logic [SKILL_W-1:0] skill);
		flow_item_t it;
		it.mode  = MODE_LOAD;
		it.stage = IDX_W'(idx);
		it.skill = skill;
		it.mana  = MANA_W'($urandom_range(16'hFFFF));
		it.first = 1'($urandom_range(1));
		item_q.push_back(it);
		gen_known[idx] = 1'b1;
		items_pushed++;
	endfunction

	// A job first gets loads for any active stage whose skill was never written, since
	// reading such an entry is outside what the block promises.
	function automatic void push_job(input logic [MANA_W-1:0] mana, input logic first);
		flow_item_t it;
		for (int i = 0; i < active_stages(gen_count); i++)
			if (!gen_known[i])
				push_load(i, pick16());
		it.mode  = MODE_JOB;
		it.stage = IDX_W'($urandom_range(MAX_STAGES - 1));
		it.skill = SKILL_W'($urandom_range(16'hFFFF));
		it.mana  = mana;
		it.first = first;
		item_q.push_back(it);
		items_pushed++;
	endfunction

	// Waits until every queued item has been taken and every result has come back. A load
	// leaves no result behind, so the task waits on afterwards to let the last one settle.
	task automatic drain();
		while (items_taken != items_pushed || span_q.size() != 0 || s_tvalid)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Writes the stage count while the block is idle, then reads it back.
	task automatic set_stages(input logic [CNT_W-1:0] cnt);
		drain();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'(4 * int'(REG_STAGE_COUNT));
		pwdata  <= APB_DW'(cnt);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		stage_reg = cnt;
		gen_count = cnt;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== APB_DW'(cnt)) begin
			errors++;
			$display("%0t: stage count read back: expected %0d, actual %0d", $time, cnt, prdata);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Input side: count each transfer and feed it to the predictor.
	always @(posedge clk) begin
		in_took = arst_n && s_tvalid && s_tready;
		if (in_took) begin
			popped_item = item_q.pop_front();
			items_taken++;
			schedule_item(popped_item);
		end
	end

	// Driver: an item once offered stays put until its transfer; otherwise the next one
	// is offered unless the sender idles this cycle or has been told to hold off.
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_took)) begin
			if (item_q.size() != 0 && !pause_send &&
			    (calm || $urandom_range(99) >= IDLE_PCT)) begin
				cur_item = item_q[0];
				s_tvalid <= 1'b1;
				s_tuser  <= cur_item.mode;
				s_tdata  <= {1'b0, cur_item.first, cur_item.mana, cur_item.skill, cur_item.stage};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result side: the receiver stalls at random, except during the calm stretch.
	always @(negedge clk) begin
		if (arst_n)
			m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	// Monitor: every result transfer is matched against the oldest expected makespan.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_span.makespan = m_tdata;
			got_span.overflow = m_tuser;
			if (span_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: makespan %0d overflow %0b",
				         $time, got_span.makespan, got_span.overflow);
			end else begin
				want_span = span_q.pop_front();
				if (got_span.makespan !== want_span.makespan) begin
					errors++;
					$display("%0t: makespan: expected %0d, actual %0d",
					         $time, want_span.makespan, got_span.makespan);
				end
				if (got_span.overflow !== want_span.overflow) begin
					errors++;
					$display("%0t: overflow: expected %0b, actual %0b",
					         $time, want_span.overflow, got_span.overflow);
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < MAX_STAGES; i++) begin
			skill_tab[i] = '0;
			fin_time[i]  = '0;
			gen_known[i] = 1'b0;
		end
		phase_stages = '{7, 64, 1, 127, 0, 23, 2, 48};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, first at the reset stage count of one: largest product, a zero
		// mana job, a zero skill, and a first job that clears earlier finish times.
		push_load(0, 16'hFFFF);
		push_job(16'hFFFF, 1'b1);
		push_job(16'h0000, 1'b0);
		push_job(16'hFFFF, 1'b0);
		push_load(0, 16'h0000);
		push_job(16'hFFFF, 1'b0);
		push_load(0, 16'h0001);
		push_job(16'h0001, 1'b1);

		// Three stages with alternating bit patterns, the top table index written too.
		set_stages(CNT_W'(3));
		push_load(1, 16'hAAAA);
		push_load(2, 16'h5555);
		push_load(MAX_STAGES - 1, 16'hFFFF);
		push_job(16'h5555, 1'b1);
		push_job(16'hAAAA, 1'b0);
		push_job(16'h0000, 1'b0);
		push_job(16'hFFFF, 1'b0);

		// Shrinking the chain leaves the last stage's finish time alone; growing it again
		// brings that stale time back into the forward pass.
		set_stages(CNT_W'(2));
		push_job(16'h1234, 1'b0);
		set_stages(CNT_W'(3));
		push_job(16'h0F0F, 1'b0);

		// Random part in phases of different stage counts, the out-of-range values zero
		// and 127 among them. One phase runs with no idling on either side, and in another
		// the sender holds off midway until every result is back.
		for (int p = 0; p < 8; p++) begin
			set_stages(CNT_W'(phase_stages[p]));
			calm = (p == 1);
			repeat (55) begin
				if ($urandom_range(99) < 25)
					push_load($urandom_range(MAX_STAGES - 1), pick16());
				else
					push_job(pick16(), $urandom_range(99) < 8);
			end
			if (p == 3) begin
				while (items_taken < items_pushed - 35)
					@(posedge clk);
				pause_send = 1'b1;
				while (s_tvalid || span_q.size() != 0)
					@(posedge clk);
				pause_send = 1'b0;
			end
		end
		calm = 1'b0;

		// A long chain of the largest products. A zero mana job levels all finish times,
		// so each following full job adds 64 products to the makespan, and a final first
		// job clears the chain again.
		set_stages(CNT_W'(MAX_STAGES));
		for (int i = 0; i < MAX_STAGES; i++)
			push_load(i, 16'hFFFF);
		push_job(16'hFFFF, 1'b1);
		repeat (16) begin
			push_job(16'h0000, 1'b0);
			push_job(16'hFFFF, 1'b0);
		end
		push_job(16'h0100, 1'b1);

		// Let anything stray surface before the verdict.
		drain();
		repeat (2 * MAX_STAGES + 8) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/nwfs_pkg.sv
rtl/core/no_wait_flow_shop_makespan.sv
dv/tb_no_wait_flow_shop_makespan.sv
